// ===== rtl/bls_pkg.sv =====
// Package with the types, codes and reset constants of the battery level smoother.
`timescale 1ns / 1ps

package bls_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [7:0] FullLevel    = 8'd100;
  localparam logic [6:0] FullLevel7   = 7'd100;
  localparam logic [6:0] SeedCapLevel = 7'd99;

  // Reset values of the configuration registers.
  localparam logic [15:0] RstLowVoltageMv      = 16'd3450;
  localparam logic [15:0] RstDeadVoltageMv     = 16'd3400;
  localparam logic [6:0]  RstNormalMaxDrop     = 7'd2;
  localparam logic [6:0]  RstLowVoltageDrop    = 7'd6;
  localparam logic [31:0] RstUpdateIntervalMs  = 32'd59000;
  localparam logic [31:0] RstLongIntervalMs    = 32'd3599000;
  localparam logic [6:0]  RstCompleteCancelLvl = 7'd96;
  localparam logic [6:0]  RstCriticalLevel     = 7'd15;

  // Reset values of the stored gauge readings.
  localparam logic [7:0]  RstRawLevel  = 8'd66;
  localparam logic [15:0] RstVoltageMv = 16'd3800;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_VOLTAGE_MV       = 3'd0,
    CFG_DEAD_VOLTAGE_MV      = 3'd1,
    CFG_NORMAL_MAX_DROP      = 3'd2,
    CFG_LOW_VOLTAGE_DROP     = 3'd3,
    CFG_UPDATE_INTERVAL_MS   = 3'd4,
    CFG_LONG_INTERVAL_MS     = 3'd5,
    CFG_COMPLETE_CANCEL_LVL  = 3'd6,
    CFG_CRITICAL_LEVEL       = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_EVENT  = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    MODE_CHARGING    = 2'd0,
    MODE_DISCHARGING = 2'd1,
    MODE_DONE        = 2'd2,
    MODE_UNKNOWN     = 2'd3
  } chg_mode_e;

  typedef enum logic [1:0] {
    STAT_DISCHARGING = 2'd0,
    STAT_CHARGING    = 2'd1,
    STAT_FULL        = 2'd2
  } chg_status_e;

  typedef enum logic [1:0] {
    CAP_NORMAL   = 2'd0,
    CAP_CRITICAL = 2'd1,
    CAP_FULL     = 2'd2
  } cap_class_e;

  typedef struct packed {
    logic [15:0] low_voltage_mv;
    logic [15:0] dead_voltage_mv;
    logic [6:0]  normal_max_drop;
    logic [6:0]  low_voltage_drop;
    logic [31:0] update_interval_ms;
    logic [31:0] long_interval_ms;
    logic [6:0]  complete_cancel_level;
    logic [6:0]  critical_level;
  } cfg_t;

  typedef struct packed {
    logic        command;
    logic [1:0]  charger_state;
    logic [7:0]  gauge_level;
    logic        gauge_level_valid;
    logic [15:0] cell_mv;
    logic        cell_mv_valid;
    logic [31:0] elapsed_ms;
  } item_t;

  typedef struct packed {
    logic [6:0]  level;
    logic [6:0]  last_level;
    logic [7:0]  raw_level;
    logic [15:0] voltage_mv;
    chg_mode_e   mode;
    logic        charge_done;
    logic        first_done;
    chg_status_e status;
  } state_t;

  typedef struct packed {
    logic [6:0] level;
    logic [1:0] charge_status;
    logic       health;
    logic [1:0] capacity_class;
    logic       notify;
    logic       poll_fast;
  } result_t;

endpackage

// ===== rtl/bls_if.sv =====
// Handshake channel interfaces for items and results of the battery level smoother.
`timescale 1ns / 1ps

interface bls_item_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [1:0]  charger_state;
  logic [7:0]  gauge_level;
  logic        gauge_level_valid;
  logic [15:0] cell_mv;
  logic        cell_mv_valid;
  logic [31:0] elapsed_ms;

  modport source (
    output valid, command, charger_state, gauge_level, gauge_level_valid,
           cell_mv, cell_mv_valid, elapsed_ms,
    input  ready
  );
  modport sink (
    input  valid, command, charger_state, gauge_level, gauge_level_valid,
           cell_mv, cell_mv_valid, elapsed_ms,
    output ready
  );
endinterface

interface bls_result_if;
  logic       valid;
  logic       ready;
  logic [6:0] level;
  logic [1:0] charge_status;
  logic       health;
  logic [1:0] capacity_class;
  logic       notify;
  logic       poll_fast;

  modport source (
    output valid, level, charge_status, health, capacity_class, notify, poll_fast,
    input  ready
  );
  modport sink (
    input  valid, level, charge_status, health, capacity_class, notify, poll_fast,
    output ready
  );
endinterface

// ===== rtl/bls_cfg_regs.sv =====
// Configuration register file of the battery level smoother.
`timescale 1ns / 1ps

module bls_cfg_regs
  import bls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LOW_VOLTAGE_MV:      cfg_d.low_voltage_mv        = cfg_wdata_i[15:0];
        CFG_DEAD_VOLTAGE_MV:     cfg_d.dead_voltage_mv       = cfg_wdata_i[15:0];
        CFG_NORMAL_MAX_DROP:     cfg_d.normal_max_drop       = cfg_wdata_i[6:0];
        CFG_LOW_VOLTAGE_DROP:    cfg_d.low_voltage_drop      = cfg_wdata_i[6:0];
        CFG_UPDATE_INTERVAL_MS:  cfg_d.update_interval_ms    = cfg_wdata_i[31:0];
        CFG_LONG_INTERVAL_MS:    cfg_d.long_interval_ms      = cfg_wdata_i[31:0];
        CFG_COMPLETE_CANCEL_LVL: cfg_d.complete_cancel_level = cfg_wdata_i[6:0];
        CFG_CRITICAL_LEVEL:      cfg_d.critical_level        = cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_voltage_mv        <= RstLowVoltageMv;
      cfg_q.dead_voltage_mv       <= RstDeadVoltageMv;
      cfg_q.normal_max_drop       <= RstNormalMaxDrop;
      cfg_q.low_voltage_drop      <= RstLowVoltageDrop;
      cfg_q.update_interval_ms    <= RstUpdateIntervalMs;
      cfg_q.long_interval_ms      <= RstLongIntervalMs;
      cfg_q.complete_cancel_level <= RstCompleteCancelLvl;
      cfg_q.critical_level        <= RstCriticalLevel;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/bls_step.sv =====
// Next-state and result logic for one sample or charger event.
`timescale 1ns / 1ps

module bls_step
  import bls_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  cfg_t                 cfg_i,
  input  item_t                item_i,
  input  state_t               state_i,
  input  logic [TIME_BITS-1:0] since_i,
  output state_t               state_o,
  output logic [TIME_BITS-1:0] since_o,
  output result_t              result_o
);

  localparam int unsigned SumW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
  localparam logic [SumW-1:0] TimeMax = {{(SumW - TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};

  logic [15:0]          volt_n;
  logic [7:0]           raw_n;
  logic [SumW-1:0]      sum_full, sum_sat, upd_ext, long_ext;
  logic [6:0]           lvl0, last0, target, dec, lvl_new;
  logic [7:0]           tgt_raw;
  logic                 discharging, updated, smp_notify, stat_notify;
  logic                 done_n;
  chg_mode_e            mode_n, st_ev;
  chg_status_e          status_n;
  logic [6:0]           level_n, last_n;

  always_comb begin
    volt_n   = item_i.cell_mv_valid ? item_i.cell_mv : state_i.voltage_mv;
    raw_n    = item_i.gauge_level_valid ? item_i.gauge_level : state_i.raw_level;
    sum_full = {{(SumW - TIME_BITS){1'b0}}, since_i} + {{(SumW - 32){1'b0}}, item_i.elapsed_ms};
    sum_sat  = (sum_full > TimeMax) ? TimeMax : sum_full;
    upd_ext  = {{(SumW - 32){1'b0}}, cfg_i.update_interval_ms};
    long_ext = {{(SumW - 32){1'b0}}, cfg_i.long_interval_ms};

    // The first sample seeds both the level and the last reported level.
    if (!state_i.first_done) begin
      lvl0  = (raw_n >= FullLevel) ? SeedCapLevel : raw_n[6:0];
      last0 = lvl0;
    end else begin
      lvl0  = state_i.level;
      last0 = state_i.last_level;
    end

    if (state_i.charge_done) begin
      tgt_raw = FullLevel;
    end else if (raw_n >= FullLevel && last0 < FullLevel7) begin
      tgt_raw = {1'b0, SeedCapLevel};
    end else begin
      tgt_raw = raw_n;
    end
    target = (tgt_raw > FullLevel) ? FullLevel7 : tgt_raw[6:0];

    discharging = (state_i.mode == MODE_DISCHARGING) || (state_i.mode == MODE_UNKNOWN);
    updated     = 1'b1;
    dec         = (target < last0) ? (last0 - target) : 7'd0;
    lvl_new     = target;
    if (discharging) begin
      if (volt_n >= cfg_i.low_voltage_mv) begin
        if (sum_sat >= long_ext) begin
          lvl_new = (target > last0) ? last0 : target;
        end else if (sum_sat < upd_ext) begin
          updated = 1'b0;
        end else begin
          lvl_new = last0 - ((dec > cfg_i.normal_max_drop) ? cfg_i.normal_max_drop : dec);
        end
      end else if (volt_n < cfg_i.dead_voltage_mv) begin
        lvl_new = 7'd0;
      end else begin
        lvl_new = (last0 <= cfg_i.low_voltage_drop) ? 7'd0 : (last0 - cfg_i.low_voltage_drop);
      end
    end else if (target > last0) begin
      lvl_new = last0 + 7'd1;
    end

    st_ev = chg_mode_e'(item_i.charger_state);
    if (item_i.command == CMD_EVENT) begin
      mode_n  = st_ev;
      if (st_ev == MODE_DONE) begin
        done_n = 1'b1;
      end else if (st_ev != MODE_CHARGING
                   || state_i.raw_level < {1'b0, cfg_i.complete_cancel_level}) begin
        done_n = 1'b0;
      end else begin
        done_n = state_i.charge_done;
      end
      level_n    = state_i.level;
      last_n     = state_i.last_level;
      smp_notify = 1'b0;
      state_o.raw_level  = state_i.raw_level;
      state_o.voltage_mv = state_i.voltage_mv;
      state_o.first_done = state_i.first_done;
      since_o            = since_i;
    end else begin
      mode_n     = state_i.mode;
      done_n     = state_i.charge_done;
      level_n    = updated ? lvl_new : lvl0;
      last_n     = level_n;
      smp_notify = (level_n != last0) && (level_n >= FullLevel7 || level_n == 7'd0);
      state_o.raw_level  = raw_n;
      state_o.voltage_mv = volt_n;
      state_o.first_done = 1'b1;
      since_o            = updated ? '0 : sum_sat[TIME_BITS-1:0];
    end

    if (mode_n == MODE_DISCHARGING || mode_n == MODE_UNKNOWN) begin
      status_n = STAT_DISCHARGING;
    end else if (level_n >= FullLevel7 && done_n) begin
      status_n = STAT_FULL;
    end else begin
      status_n = STAT_CHARGING;
    end
    stat_notify = (status_n != state_i.status);

    state_o.level       = level_n;
    state_o.last_level  = last_n;
    state_o.mode        = mode_n;
    state_o.charge_done = done_n;
    state_o.status      = status_n;

    result_o.level         = level_n;
    result_o.charge_status = status_n;
    result_o.notify        = smp_notify | stat_notify;
    result_o.poll_fast     = (status_n != STAT_DISCHARGING);
    if (level_n >= FullLevel7) begin
      result_o.capacity_class = CAP_FULL;
      result_o.health         = 1'b0;
    end else if (level_n < cfg_i.critical_level) begin
      result_o.capacity_class = CAP_CRITICAL;
      result_o.health         = 1'b1;
    end else begin
      result_o.capacity_class = CAP_NORMAL;
      result_o.health         = 1'b0;
    end
  end

endmodule

// ===== rtl/battery_level_smoother.sv =====
// Top level of the battery level smoother: input stage, state, result register.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake     Carries
//  in_i      sink       valid/ready   one sample or charger event per transaction
//  out_o     source     valid/ready   one smoothed level and status per transaction
//  cfg_*     input      write enable  configuration register writes, no read-back
//
// Every transaction gives exactly one result. The accepting edge loads the
// input register. The update logic then works on it, and the edge on which the
// buffered transaction moves on loads the result register; an output stall can
// hold it in the input register. A new transaction is taken in every
// cycle while results drain. Reset loads the power-on level, readings and
// configuration at once.
// A stall on the output holds the result register and the input register; the
// input side stays ready as long as the input register is empty.
//
// The state kept between transactions is the reported level, the last level
// that was announced, the latest raw gauge level and cell voltage, the charger
// mode with its charge-complete flag, the saturating time accumulator and the
// current status. Samples move the level; charger events move only the mode, the charge-complete flag and the status.

module battery_level_smoother
  import bls_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bls_item_if.sink            in_i,
  bls_result_if.source        out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t                 cfg;
  item_t                item_q, item_d;
  logic                 item_valid_q;
  state_t               state_q, state_d;
  logic [TIME_BITS-1:0] since_q, since_d;
  result_t              res_q, res_d;
  logic                 res_valid_q;
  logic                 advance, in_take;

  bls_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bls_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .cfg_i    (cfg),
    .item_i   (item_q),
    .state_i  (state_q),
    .since_i  (since_q),
    .state_o  (state_d),
    .since_o  (since_d),
    .result_o (res_d)
  );

  // The buffered transaction moves on whenever the result register is free or
  // is being emptied in this cycle.
  assign advance    = item_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    item_d.command           = in_i.command;
    item_d.charger_state     = in_i.charger_state;
    item_d.gauge_level       = in_i.gauge_level;
    item_d.gauge_level_valid = in_i.gauge_level_valid;
    item_d.cell_mv           = in_i.cell_mv;
    item_d.cell_mv_valid     = in_i.cell_mv_valid;
    item_d.elapsed_ms        = in_i.elapsed_ms;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (in_take) begin
        item_valid_q <= 1'b1;
      end else if (advance) begin
        item_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.level       <= '0;
      state_q.last_level  <= '0;
      state_q.raw_level   <= RstRawLevel;
      state_q.voltage_mv  <= RstVoltageMv;
      state_q.mode        <= MODE_DISCHARGING;
      state_q.charge_done <= 1'b0;
      state_q.first_done  <= 1'b0;
      state_q.status      <= STAT_DISCHARGING;
      since_q             <= '0;
    end else if (advance) begin
      state_q <= state_d;
      since_q <= since_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = res_valid_q;
  assign out_o.level          = res_q.level;
  assign out_o.charge_status  = res_q.charge_status;
  assign out_o.health         = res_q.health;
  assign out_o.capacity_class = res_q.capacity_class;
  assign out_o.notify         = res_q.notify;
  assign out_o.poll_fast      = res_q.poll_fast;

endmodule
